// ===== hdl/icaf_pkg.sv =====
// Shared types and constants for the IMU complementary attitude filter.
// Used by every module of the block; depends on nothing else.
package icaf_pkg;

   localparam int REQ_W = 96;
   localparam int RSP_W = 112;
   localparam int QUEUE_DEPTH = 2;
   localparam int TABLE_LEN = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_WEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_YAW_THRESHOLD = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BOOST_AMOUNT = 2'd3;

   // ceil(2^24 / 131): exact truncating quotient for magnitudes up to 2^15.
   localparam logic [17:0] RATE_RECIP = 18'd128071;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic signed [16:0] TILT_LIMIT = 17'sd23040;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [16:0] mag_x;
      logic [16:0] mag_y;
      logic [16:0] mag_z;
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic all_zero;
   } sample_type;

   typedef struct packed {
      logic [15:0] sample_period;
      logic [16:0] gyro_weight;
      logic signed [23:0] yaw_threshold;
      logic [7:0] boost_amount;
   } cfg_type;

   // atan(2^-i) in 1/65536 degree.
   function automatic logic [22:0] atan_entry(input logic [4:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0: v = 23'd2949120;
         5'd1: v = 23'd1740967;
         5'd2: v = 23'd919879;
         5'd3: v = 23'd466945;
         5'd4: v = 23'd234379;
         5'd5: v = 23'd117304;
         5'd6: v = 23'd58666;
         5'd7: v = 23'd29335;
         5'd8: v = 23'd14668;
         5'd9: v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/imu_complementary_attitude_filter.sv =====
// IMU complementary attitude filter, top level: configuration registers and
// the front end, queue and back end. Depends on icaf_pkg and all icaf_ modules.
//
// Each request carries one six-axis IMU sample and yields exactly one result:
// the accelerometer-only roll and pitch tilts, the filtered roll and pitch,
// the integrated yaw and the current boost, all angles in 1/256 degree.
// A request is taken into a front register and a two-entry queue while the
// back end works, so the port keeps accepting up to three requests ahead of
// the engine. The back end handles one sample at a time in these steps:
// a step to take the sample, three squares, then three rate quotients and
// three rate products on one shared multiplier and the yaw update while the
// two tilt lanes run in parallel (square-root digit steps, CORDIC rotation
// steps and a rounding step), then four sequencer steps per blended axis and
// a step to load the result register. The back end waits for the tilt lanes,
// so their square root and CORDIC steps set the time per sample. A sample
// whose accelerometer axes are all zero skips the lanes. A stalled result
// port holds the back end in its last step. Configuration writes take effect
// at once and are meant to be made while no sample is in flight.
module imu_complementary_attitude_filter #(
   parameter int ANGLE_WIDTH = 24,
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   // Request: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each).
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,
   // Result: roll_tilt[15:0], pitch_tilt[31:16], roll_angle[55:32],
   // pitch_angle[79:56], yaw_angle[103:80], current_boost[111:104].
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,
   // Register writes: 0 sample_period, 1 gyro_weight, 2 yaw_threshold,
   // 3 boost_amount.
   input  logic          csr_wen,
   input  logic [1:0]    csr_addr,
   input  logic [23:0]   csr_wdata
);
   import icaf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic push_valid, push_ready, pop_valid, pop_ready;
   sample_type push_item, pop_item;

   // Register file update.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_SAMPLE_PERIOD: cfg_in.sample_period = csr_wdata[15:0];
            REG_GYRO_WEIGHT: cfg_in.gyro_weight = csr_wdata[16:0];
            REG_YAW_THRESHOLD: cfg_in.yaw_threshold = $signed(csr_wdata);
            REG_BOOST_AMOUNT: cfg_in.boost_amount = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= 16'd2048;
         cfg_ff.gyro_weight <= 17'd64225;
         cfg_ff.yaw_threshold <= 24'sd7680;
         cfg_ff.boost_amount <= 8'd25;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end splits and classifies each request.
   icaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Samples wait here while the back end is busy.
   icaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // The back end computes and holds the filter state and the result register.
   icaf_back #(
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/icaf_front.sv =====
// Front end: takes requests, splits them into fields and classifies them.
// Depends on icaf_pkg.
module icaf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [95:0]              req_tdata,
   output logic                     push_valid,
   input  logic                     push_ready,
   output icaf_pkg::sample_type     push_item
);
   import icaf_pkg::*;

   logic hold_valid_ff, hold_valid_in;
   sample_type hold_ff, hold_in;
   sample_type cls;
   logic signed [16:0] rx, ry, rz;
   logic accept;

   always_comb begin
      rx = 17'($signed(req_tdata[63:48]));
      ry = 17'($signed(req_tdata[79:64]));
      rz = 17'($signed(req_tdata[95:80]));
      cls.accel_x = $signed(req_tdata[15:0]);
      cls.accel_y = $signed(req_tdata[31:16]);
      cls.accel_z = $signed(req_tdata[47:32]);
      cls.neg_x = rx[16];
      cls.neg_y = ry[16];
      cls.neg_z = rz[16];
      cls.mag_x = rx[16] ? 17'(-rx) : 17'(rx);
      cls.mag_y = ry[16] ? 17'(-ry) : 17'(ry);
      cls.mag_z = rz[16] ? 17'(-rz) : 17'(rz);
      cls.all_zero = (req_tdata[47:0] == 48'd0);
   end

   assign req_tready = !hold_valid_ff || push_ready;
   assign accept = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_item = hold_ff;

   always_comb begin
      hold_in = accept ? cls : hold_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ===== hdl/icaf_queue.sv =====
// Short queue between the front end and the back end.
// Depends on icaf_pkg.
module icaf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  icaf_pkg::sample_type     push_item,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output icaf_pkg::sample_type     pop_item
);
   import icaf_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

   sample_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item = slot_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/icaf_tilt.sv =====
// One tilt lane: digit-by-digit square root followed by a vectoring CORDIC.
// Depends on icaf_pkg.
module icaf_tilt #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                zero,
   input  logic signed [16:0]  num,
   input  logic [31:0]         sumsq,
   output logic                busy,
   output logic signed [15:0]  tilt
);
   import icaf_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam logic [4:0] LAST_ROT = 5'(NSTEP - 1);
   localparam logic [4:0] LAST_ROOT = 5'd23;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_ROOT = 2'd1;
   localparam logic [1:0] T_ROT = 2'd2;
   localparam logic [1:0] T_FIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [47:0] rad_ff, rad_in;
   logic [26:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic signed [27:0] x_ff, x_in, y_ff, y_in;
   logic signed [24:0] z_ff, z_in;
   logic signed [16:0] num_ff, num_in;
   logic signed [15:0] tilt_ff, tilt_in;

   logic [26:0] rem_sh, trial;
   logic signed [27:0] dx, dy;
   logic signed [24:0] ang, zr;

   assign busy = (state_ff != T_IDLE);
   assign tilt = tilt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      num_in = num_ff;
      tilt_in = tilt_ff;
      rem_sh = {rem_ff[24:0], rad_ff[47:46]};
      trial = {1'b0, root_ff, 2'b01};
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      ang = $signed({2'b00, atan_entry(cnt_ff)});
      zr = (z_ff + 25'sd128) >>> 8;
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               if (zero) begin
                  tilt_in = '0;
               end else begin
                  rad_in = {sumsq, 16'd0};
                  rem_in = '0;
                  root_in = '0;
                  num_in = num;
                  cnt_in = '0;
                  state_in = T_ROOT;
               end
            end
         end
         T_ROOT: begin
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[22:0], 1'b0};
            end
            rad_in = {rad_ff[45:0], 2'b00};
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_ROOT) begin
               // The root is complete: seed the rotation.
               x_in = $signed({4'd0, root_in});
               y_in = $signed({{3{num_ff[16]}}, num_ff, 8'd0});
               z_in = '0;
               cnt_in = '0;
               state_in = T_ROT;
            end
         end
         T_ROT: begin
            if (y_ff < 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ang;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ang;
            end
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_ROT) begin
               state_in = T_FIN;
            end
         end
         T_FIN: begin
            if (zr > 25'(TILT_LIMIT)) begin
               tilt_in = 16'(TILT_LIMIT);
            end else if (zr < -25'(TILT_LIMIT)) begin
               tilt_in = 16'(-TILT_LIMIT);
            end else begin
               tilt_in = 16'(zr);
            end
            state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      num_ff <= num_in;
      tilt_ff <= tilt_in;
   end

endmodule

// ===== hdl/icaf_back.sv =====
// Back end: sequencer around one shared multiplier and two tilt lanes,
// holding the filter state and the result register. Depends on icaf_pkg, icaf_tilt.
module icaf_back #(
   parameter int ANGLE_WIDTH = 24,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  icaf_pkg::cfg_type        cfg,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  icaf_pkg::sample_type     pop_item,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [111:0]             rsp_tdata
);
   import icaf_pkg::*;

   localparam int AW = ANGLE_WIDTH;
   localparam int DW = AW + 10;
   localparam int HW = DW - 20;
   localparam int SW = AW + 28;
   localparam int RW = SW - 24;
   localparam int YW = ((AW > 26) ? AW : 26) + 1;
   localparam logic signed [RW-1:0] RMAX = RW'((64'sd1 <<< (AW - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] RMIN = -RMAX - RW'(1);
   localparam logic signed [AW-1:0] AMAX = AW'((64'sd1 <<< (AW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] AMIN = -AMAX - AW'(1);
   localparam logic [SW-1:0] ROUND_HALF = SW'(64'd8388608);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SQX = 5'd1;
   localparam logic [4:0] ST_SQY = 5'd2;
   localparam logic [4:0] ST_SQZ = 5'd3;
   localparam logic [4:0] ST_QX = 5'd4;
   localparam logic [4:0] ST_QY = 5'd5;
   localparam logic [4:0] ST_QZ = 5'd6;
   localparam logic [4:0] ST_PX = 5'd7;
   localparam logic [4:0] ST_PY = 5'd8;
   localparam logic [4:0] ST_PZ = 5'd9;
   localparam logic [4:0] ST_YAW = 5'd10;
   localparam logic [4:0] ST_WAIT = 5'd11;
   localparam logic [4:0] ST_DIFF = 5'd12;
   localparam logic [4:0] ST_MLO = 5'd13;
   localparam logic [4:0] ST_MHI = 5'd14;
   localparam logic [4:0] ST_SUM = 5'd15;
   localparam logic [4:0] ST_OUT = 5'd16;

   logic [4:0] state_ff, state_in;
   sample_type item_ff, item_in;
   logic [30:0] sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic [7:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic signed [25:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [AW-1:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic boost_ff, boost_in;
   logic lane_ff, lane_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [43:0] lo_ff, lo_in, hi_ff, hi_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [111:0] rsp_data_ff, rsp_data_in;

   logic signed [25:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [43:0] mul_p;
   logic [16:0] weight;
   logic signed [8:0] qsel;
   logic signed [AW-1:0] cur_store;
   logic signed [25:0] cur_rate;
   logic signed [15:0] cur_tilt;
   logic signed [SW-1:0] total;
   logic signed [RW-1:0] blended;
   logic signed [AW-1:0] blend_sat;
   logic signed [25:0] yaw_inc;
   logic signed [YW-1:0] yaw_sum;
   logic signed [AW-1:0] yaw_sat;
   logic signed [HW-1:0] diff_hi;
   logic out_free;

   logic tilt_start;
   logic roll_busy, pitch_busy;
   logic signed [15:0] roll_tilt, pitch_tilt;
   logic signed [16:0] pitch_num, roll_num;
   logic [31:0] pitch_sumsq, roll_sumsq;

   assign tilt_start = (state_ff == ST_QX);
   assign pitch_num = -17'(item_ff.accel_x);
   assign roll_num = 17'(item_ff.accel_y);
   assign pitch_sumsq = 32'(sqy_ff) + 32'(sqz_ff);
   assign roll_sumsq = 32'(sqx_ff) + 32'(sqz_ff);

   icaf_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll_tilt (
      .clock  (clock),
      .reset  (reset),
      .start  (tilt_start),
      .zero   (item_ff.all_zero),
      .num    (roll_num),
      .sumsq  (roll_sumsq),
      .busy   (roll_busy),
      .tilt   (roll_tilt)
   );

   icaf_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch_tilt (
      .clock  (clock),
      .reset  (reset),
      .start  (tilt_start),
      .zero   (item_ff.all_zero),
      .num    (pitch_num),
      .sumsq  (pitch_sumsq),
      .busy   (pitch_busy),
      .tilt   (pitch_tilt)
   );

   assign weight = (cfg.gyro_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.gyro_weight;
   assign diff_hi = diff_ff[DW-1:20];
   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      qsel = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = 26'(item_ff.accel_x);
            mul_b = 18'(item_ff.accel_x);
         end
         ST_SQY: begin
            mul_a = 26'(item_ff.accel_y);
            mul_b = 18'(item_ff.accel_y);
         end
         ST_SQZ: begin
            mul_a = 26'(item_ff.accel_z);
            mul_b = 18'(item_ff.accel_z);
         end
         ST_QX: begin
            mul_a = $signed({8'd0, RATE_RECIP});
            mul_b = $signed({1'b0, item_ff.mag_x});
         end
         ST_QY: begin
            mul_a = $signed({8'd0, RATE_RECIP});
            mul_b = $signed({1'b0, item_ff.mag_y});
         end
         ST_QZ: begin
            mul_a = $signed({8'd0, RATE_RECIP});
            mul_b = $signed({1'b0, item_ff.mag_z});
         end
         ST_PX, ST_PY, ST_PZ: begin
            if (state_ff == ST_PX) begin
               qsel = item_ff.neg_x ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
            end else if (state_ff == ST_PY) begin
               qsel = item_ff.neg_y ? -$signed({1'b0, qy_ff}) : $signed({1'b0, qy_ff});
            end else begin
               qsel = item_ff.neg_z ? -$signed({1'b0, qz_ff}) : $signed({1'b0, qz_ff});
            end
            mul_a = $signed({10'd0, cfg.sample_period});
            mul_b = 18'(qsel);
         end
         ST_MLO: begin
            mul_a = $signed({6'd0, diff_ff[19:0]});
            mul_b = $signed({1'b0, weight});
         end
         ST_MHI: begin
            mul_a = 26'(diff_hi);
            mul_b = $signed({1'b0, weight});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      cur_store = lane_ff ? pitch_ff : roll_ff;
      cur_rate = lane_ff ? py_ff : px_ff;
      cur_tilt = lane_ff ? pitch_tilt : roll_tilt;

      total = $signed({hi_ff[SW-21:0], 20'd0})
            + $signed({{(SW-38){1'b0}}, lo_ff[37:0]})
            + $signed({{(SW-40){cur_tilt[15]}}, cur_tilt, 24'd0})
            + $signed(ROUND_HALF);
      blended = RW'(total >>> 24);
      if (blended > RMAX) begin
         blend_sat = AMAX;
      end else if (blended < RMIN) begin
         blend_sat = AMIN;
      end else begin
         blend_sat = AW'(blended);
      end

      // The sum is wide enough for the largest increment at any angle width.
      yaw_inc = (pz_ff + 26'sd128) >>> 8;
      yaw_sum = YW'(yaw_ff) + YW'(yaw_inc);
      if (yaw_sum > YW'(AMAX)) begin
         yaw_sat = AMAX;
      end else if (yaw_sum < YW'(AMIN)) begin
         yaw_sat = AMIN;
      end else begin
         yaw_sat = AW'(yaw_sum);
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      sqx_in = sqx_ff;
      sqy_in = sqy_ff;
      sqz_in = sqz_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      qz_in = qz_ff;
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      yaw_in = yaw_ff;
      boost_in = boost_ff;
      lane_in = lane_ff;
      diff_in = diff_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               item_in = pop_item;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sqx_in = mul_p[30:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in = mul_p[30:0];
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            sqz_in = mul_p[30:0];
            state_in = ST_QX;
         end
         ST_QX: begin
            qx_in = mul_p[31:24];
            state_in = ST_QY;
         end
         ST_QY: begin
            qy_in = mul_p[31:24];
            state_in = ST_QZ;
         end
         ST_QZ: begin
            qz_in = mul_p[31:24];
            state_in = ST_PX;
         end
         ST_PX: begin
            px_in = mul_p[25:0];
            state_in = ST_PY;
         end
         ST_PY: begin
            py_in = mul_p[25:0];
            state_in = ST_PZ;
         end
         ST_PZ: begin
            pz_in = mul_p[25:0];
            state_in = ST_YAW;
         end
         ST_YAW: begin
            yaw_in = yaw_sat;
            if (33'(yaw_sat) > 33'(cfg.yaw_threshold)) begin
               boost_in = 1'b1;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!roll_busy && !pitch_busy) begin
               lane_in = 1'b0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in = (DW'(cur_store) <<< 8) + DW'(cur_rate) - (DW'(cur_tilt) <<< 8);
            state_in = ST_MLO;
         end
         ST_MLO: begin
            lo_in = mul_p;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            hi_in = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (lane_ff) begin
               pitch_in = blend_sat;
               state_in = ST_OUT;
            end else begin
               roll_in = blend_sat;
               lane_in = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_in = {boost_ff ? cfg.boost_amount : 8'd0,
                              24'(yaw_ff), 24'(pitch_ff), 24'(roll_ff),
                              pitch_tilt, roll_tilt};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
         boost_ff <= 1'b0;
         lane_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff <= yaw_in;
         boost_ff <= boost_in;
         lane_ff <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sqz_ff <= sqz_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      qz_ff <= qz_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      diff_ff <= diff_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/imu_complementary_attitude_filter_test.sv =====
// Testbench for the IMU complementary attitude filter: directed table, a yaw saturation run and random samples,
// every result checked against an in-bench attitude predictor. Depends on icaf_pkg and the RTL.
module imu_complementary_attitude_filter_test;
   import icaf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_W = 24;
   localparam int STEPS = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_COUNT = 490;
   localparam int SAT_COUNT = 135;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [1:0] csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   always #1 clock = ~clock;

   imu_complementary_attitude_filter i_dut (.*);

   // One expected result: the fields of rsp_tdata from the lowest bit up.
   typedef struct {
      logic signed [15:0] roll_tilt;
      logic signed [15:0] pitch_tilt;
      logic signed [23:0] roll_angle;
      logic signed [23:0] pitch_angle;
      logic signed [23:0] yaw_angle;
      logic [7:0] current_boost;
   } attitude_type;

   attitude_type expected_attitudes[$];
   int mismatch_count = 0;
   int result_count = 0;
   int idle_cycles = 0;
   int sent_count = 0;
   bit check_rows[$];

   // Predictor copy of the block's registers and stored angles.
   cfg_type cfg;
   longint roll_acc, pitch_acc, yaw_acc;
   bit boost_on;

   longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   function automatic longint floor_div2(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_div2(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint clamp_angle(longint v);
      longint hi = (longint'(1) << (ANGLE_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Vectoring CORDIC arctangent of num over the root of sumsq, 1/256 degree.
   function automatic longint tilt_angle(longint num, longint unsigned sumsq);
      longint x, y, z = 0, dx, dy;
      if (num == 0 && sumsq == 0) return 0;
      x = int_sqrt(sumsq << 16);
      y = num * 256;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = floor_div2(y, i);
         dy = floor_div2(x, i);
         if (y < 0) begin
            x -= dx; y += dy; z -= atan_deg[i];
         end else begin
            x += dx; y -= dy; z += atan_deg[i];
         end
      end
      z = round_div2(z, 8);
      if (z > 23040) z = 23040;
      if (z < -23040) z = -23040;
      return z;
   endfunction

   function automatic longint blend_axis(longint acc, longint rate, longint tilt_v);
      longint w = (cfg.gyro_weight > 65536) ? 65536 : longint'(cfg.gyro_weight);
      longint g = acc * 256 + rate * longint'(cfg.sample_period);
      return clamp_angle(round_div2(w * g + (65536 - w) * tilt_v * 256, 24));
   endfunction

   function automatic attitude_type predict_attitude(logic [95:0] sample);
      attitude_type r;
      longint ax = longint'($signed(sample[15:0]));
      longint ay = longint'($signed(sample[31:16]));
      longint az = longint'($signed(sample[47:32]));
      longint gx = longint'($signed(sample[63:48])) / 131;
      longint gy = longint'($signed(sample[79:64])) / 131;
      longint gz = longint'($signed(sample[95:80])) / 131;
      longint pt = tilt_angle(-ax, ay * ay + az * az);
      longint rt = tilt_angle(ay, ax * ax + az * az);
      roll_acc = blend_axis(roll_acc, gx, rt);
      pitch_acc = blend_axis(pitch_acc, gy, pt);
      yaw_acc = clamp_angle(round_div2(yaw_acc * 256 + gz * longint'(cfg.sample_period), 8));
      if (yaw_acc > longint'(cfg.yaw_threshold)) boost_on = 1'b1;
      r.roll_tilt = rt[15:0];
      r.pitch_tilt = pt[15:0];
      r.roll_angle = roll_acc[23:0];
      r.pitch_angle = pitch_acc[23:0];
      r.yaw_angle = yaw_acc[23:0];
      r.current_boost = boost_on ? cfg.boost_amount : 8'd0;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               result_count, field, got, want);
      mismatch_count++;
   endtask

   // Result side: random stall pattern, compare every accepted result.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 40) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      attitude_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_attitudes.size() == 0) begin
            $display("unexpected result %0d", result_count);
            mismatch_count++;
         end else begin
            e = expected_attitudes.pop_front();
            if (rsp_tdata[15:0] !== e.roll_tilt)
               report_mismatch("roll_tilt", $signed(rsp_tdata[15:0]), e.roll_tilt);
            if (rsp_tdata[31:16] !== e.pitch_tilt)
               report_mismatch("pitch_tilt", $signed(rsp_tdata[31:16]), e.pitch_tilt);
            if (rsp_tdata[55:32] !== e.roll_angle)
               report_mismatch("roll_angle", $signed(rsp_tdata[55:32]), e.roll_angle);
            if (rsp_tdata[79:56] !== e.pitch_angle)
               report_mismatch("pitch_angle", $signed(rsp_tdata[79:56]), e.pitch_angle);
            if (rsp_tdata[103:80] !== e.yaw_angle)
               report_mismatch("yaw_angle", $signed(rsp_tdata[103:80]), e.yaw_angle);
            if (rsp_tdata[111:104] !== e.current_boost)
               report_mismatch("current_boost", rsp_tdata[111:104], e.current_boost);
         end
         result_count++;
      end
   end

   // Watchdog: cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("imu_complementary_attitude_filter test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Register write; the predictor follows the same masks as the block.
   // The enable drops for a cycle so that writes never share a time step.
   task automatic write_register(logic [1:0] idx, logic [23:0] value);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         REG_SAMPLE_PERIOD: cfg.sample_period = value[15:0];
         REG_GYRO_WEIGHT: cfg.gyro_weight = value[16:0];
         REG_YAW_THRESHOLD: cfg.yaw_threshold = value;
         REG_BOOST_AMOUNT: cfg.boost_amount = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Every request produces a result, so idle means the queue is empty.
   task automatic wait_idle();
      while (expected_attitudes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Burst-and-gap sender. The valid stays high across back-to-back requests;
   // a request sent without keep_valid is followed by a gap with the valid low.
   int burst_left = 0;
   bit valid_drop = 1'b0;
   task automatic send_sample(logic [95:0] sample, bit keep_valid);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 90) : 0;
         burst_left = $urandom_range(1, 12);
      end
      if (valid_drop && gap == 0) gap = 1;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_attitudes.push_back(predict_attitude(sample));
      sent_count++;
      burst_left--;
      valid_drop = !keep_valid;
   endtask

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   // Directed rows: sample and, where it is obvious, the tilt pair it must give.
   typedef struct {
      logic [95:0] sample;
      bit has_tilt;
      logic signed [15:0] roll_t;
      logic signed [15:0] pitch_t;
   } stimulus_row_type;

   stimulus_row_type directed_rows[] = '{
      // All axes zero: both tilts are zero.
      '{96'h0, 1'b1, 16'sd0, 16'sd0},
      // Level, z only: no tilt.
      '{{48'h0, 16'd16384, 32'h0}, 1'b1, 16'sd0, 16'sd0},
      '{{48'h0, 16'h8000, 32'h0}, 1'b1, 16'sd0, 16'sd0},
      '{{48'h0, 16'h0000, 16'h7FFF, 16'h0000}, 1'b0, 16'sd0, 16'sd0},
      '{{48'h0, 16'h0000, 16'h8000, 16'h0000}, 1'b0, 16'sd0, 16'sd0},
      '{{48'h0, 16'h0000, 16'h0000, 16'h7FFF}, 1'b0, 16'sd0, 16'sd0},
      '{{48'h0, 16'h0000, 16'h0000, 16'h8000}, 1'b0, 16'sd0, 16'sd0},
      '{{48'h0, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 16'sd0, 16'sd0},
      '{{48'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, 16'sd0, 16'sd0},
      // Gyro extremes, including values just around one degree per second.
      '{{16'h7FFF, 16'h7FFF, 16'h7FFF, 48'h0}, 1'b1, 16'sd0, 16'sd0},
      '{{16'h8000, 16'h8000, 16'h8000, 48'h0}, 1'b1, 16'sd0, 16'sd0},
      '{{16'd131, 16'd130, 16'hFF7D, 16'h0, 16'h0, 16'd100}, 1'b0, 16'sd0, 16'sd0},
      '{{16'hFFFF, 16'h0001, 16'hFF7E, 16'd5, 16'hFFFB, 16'd9}, 1'b0, 16'sd0, 16'sd0},
      '{{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 16'sd0, 16'sd0},
      '{{16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001}, 1'b0, 16'sd0, 16'sd0}
   };

   initial begin
      logic [95:0] s;
      attitude_type peek;
      cfg = '{sample_period: 16'd2048, gyro_weight: 17'd64225,
              yaw_threshold: 24'sd7680, boost_amount: 8'd25};
      roll_acc = 0; pitch_acc = 0; yaw_acc = 0; boost_on = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset settings; typed tilts checked at the source.
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample, 1'b0);
         if (directed_rows[i].has_tilt) begin
            peek = expected_attitudes[$];
            if (peek.roll_tilt !== directed_rows[i].roll_t ||
                peek.pitch_tilt !== directed_rows[i].pitch_t)
               report_mismatch("table tilt", peek.roll_tilt, directed_rows[i].roll_t);
         end
      end
      req_tvalid <= 1'b0;
      wait_idle();

      // Drive yaw into saturation with a long period and full rate, then back.
      write_register(REG_SAMPLE_PERIOD, 24'hFFFF);
      write_register(REG_GYRO_WEIGHT, 24'd65536);
      write_register(REG_YAW_THRESHOLD, 24'h7FFFFF);
      write_register(REG_BOOST_AMOUNT, 24'hFF);
      for (int i = 0; i < SAT_COUNT; i++)
         send_sample({16'h7FFF, 16'h7FFF, 16'h8000, 48'h0}, 1'b1);
      for (int i = 0; i < 5; i++) send_sample({16'h8000, 16'h8000, 16'h7FFF, 48'h0}, 1'b0);
      req_tvalid <= 1'b0;
      wait_idle();

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_register(REG_GYRO_WEIGHT, 24'h1FFFF);
               write_register(REG_YAW_THRESHOLD, 24'h800000);
            end
            1: begin
               write_register(REG_SAMPLE_PERIOD, 24'd0);
               write_register(REG_GYRO_WEIGHT, 24'd0);
               write_register(REG_BOOST_AMOUNT, 24'd0);
            end
            2: begin
               write_register(REG_SAMPLE_PERIOD, 24'd2048);
               write_register(REG_GYRO_WEIGHT, 24'd64225);
               write_register(REG_YAW_THRESHOLD, 24'd7680);
               write_register(REG_BOOST_AMOUNT, 24'd25);
            end
            default: begin
               write_register(REG_SAMPLE_PERIOD, 24'($urandom));
               write_register(REG_GYRO_WEIGHT, 24'($urandom_range(0, 131071)));
               write_register(REG_YAW_THRESHOLD, 24'($urandom));
               write_register(REG_BOOST_AMOUNT, 24'($urandom));
            end
         endcase
         for (int i = 0; i < RANDOM_COUNT / 7; i++) begin
            for (int k = 0; k < 6; k++) s[k*16 +: 16] = pick_axis();
            send_sample(s, (i + 1 < RANDOM_COUNT / 7) && ($urandom_range(0, 2) != 0));
         end
         req_tvalid <= 1'b0;
         wait_idle();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d samples across 9 register settings, %0d results checked",
               sent_count, result_count);
      if (mismatch_count == 0 && expected_attitudes.size() == 0) begin
         $display("imu_complementary_attitude_filter test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_attitudes.size());
         $display("imu_complementary_attitude_filter test failed");
      end
      $finish;
   end
endmodule
